@@ sv/ihc_pkg.sv @@
// shared types and constants of the iteration hue colorizer
package ihc_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int LIMIT_RESET        = 100;
    localparam int CHAN_BITS          = 8;
    localparam int CFG_INDEX_BITS     = 1;
    localparam int SECTOR_BITS        = 3;

    localparam logic [CHAN_BITS-1:0] CHAN_FULL  = 8'hff;
    localparam logic [CHAN_BITS-1:0] CHAN_ZERO  = 8'h00;
    localparam logic [CHAN_BITS-1:0] CHAN_FLOOR = 8'h30;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ITERATION_LIMIT = 1'b0,
        REG_PALETTE_MODE    = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_RED   = 2'd1,
        MODE_BLUE  = 2'd2,
        MODE_GREY  = 2'd3
    } palette_mode_t;

    typedef logic [SECTOR_BITS-1:0] sector_t;

    localparam sector_t SECTOR_GREEN_UP   = 3'd0;
    localparam sector_t SECTOR_RED_DOWN   = 3'd1;
    localparam sector_t SECTOR_BLUE_UP    = 3'd2;
    localparam sector_t SECTOR_GREEN_DOWN = 3'd3;
    localparam sector_t SECTOR_RED_UP     = 3'd4;
    localparam sector_t SECTOR_BLUE_DOWN  = 3'd5;
    localparam sector_t SECTOR_FULL_RED   = 3'd6;

endpackage

@@ sv/ihc_sector.sv @@
// count clamp and restoring division of six times the count by the limit
module ihc_sector #(
    parameter int COUNT_BITS = ihc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [COUNT_BITS-1:0] in_count,
    input  logic [COUNT_BITS-1:0] limit,
    output logic                  out_valid,
    output ihc_pkg::sector_t      out_sector,
    output logic [COUNT_BITS-1:0] out_rem
);

    localparam int STEPS = ihc_pkg::SECTOR_BITS;
    localparam int PW    = COUNT_BITS + STEPS;

    logic [COUNT_BITS-1:0] count_clamped;
    logic [PW-1:0]         six_count;
    logic [PW-1:0]         part_reg [0:STEPS];
    logic [PW-1:0]         part_next [1:STEPS];
    logic [STEPS-1:0]      quo_reg [0:STEPS];
    logic [STEPS-1:0]      quo_next [1:STEPS];
    logic [PW-1:0]         div_sh [0:STEPS-1];
    logic [STEPS:0]        valid_reg;

    always_comb begin
        count_clamped = (in_count > limit) ? limit : in_count;
        six_count     = (PW'(count_clamped) << 2) + (PW'(count_clamped) << 1);
        for (int i = 0; i < STEPS; i++) begin
            div_sh[i] = PW'(limit) << (STEPS - 1 - i);
            if (part_reg[i] >= div_sh[i]) begin
                part_next[i+1] = part_reg[i] - div_sh[i];
                quo_next[i+1]  = {quo_reg[i][STEPS-2:0], 1'b1};
            end else begin
                part_next[i+1] = part_reg[i];
                quo_next[i+1]  = {quo_reg[i][STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            part_reg[0] <= six_count;
            quo_reg[0]  <= '0;
            for (int i = 1; i <= STEPS; i++) begin
                part_reg[i] <= part_next[i];
                quo_reg[i]  <= quo_next[i];
            end
        end
    end

    assign out_valid  = valid_reg[STEPS];
    assign out_sector = quo_reg[STEPS];
    assign out_rem    = part_reg[STEPS][COUNT_BITS-1:0];

endmodule

@@ sv/ihc_ramp.sv @@
// restoring division of 255 times the remainder by the limit, one quotient bit a stage
module ihc_ramp #(
    parameter int COUNT_BITS = ihc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  ihc_pkg::sector_t                 in_sector,
    input  logic [COUNT_BITS-1:0]            in_rem,
    input  logic [COUNT_BITS-1:0]            limit,
    output logic                             out_valid,
    output ihc_pkg::sector_t                 out_sector,
    output logic [ihc_pkg::CHAN_BITS-1:0]    out_up,
    output logic                             out_inexact
);

    localparam int STEPS = ihc_pkg::CHAN_BITS;
    localparam int PW    = COUNT_BITS + STEPS;

    logic [PW-1:0]            part_reg [0:STEPS];
    logic [PW-1:0]            part_next [1:STEPS];
    logic [STEPS-1:0]         quo_reg [0:STEPS];
    logic [STEPS-1:0]         quo_next [1:STEPS];
    ihc_pkg::sector_t         sector_reg [0:STEPS];
    logic [PW-1:0]            div_sh [0:STEPS-1];
    logic [STEPS:0]           valid_reg;

    always_comb begin
        for (int i = 0; i < STEPS; i++) begin
            div_sh[i] = PW'(limit) << (STEPS - 1 - i);
            if (part_reg[i] >= div_sh[i]) begin
                part_next[i+1] = part_reg[i] - div_sh[i];
                quo_next[i+1]  = {quo_reg[i][STEPS-2:0], 1'b1};
            end else begin
                part_next[i+1] = part_reg[i];
                quo_next[i+1]  = {quo_reg[i][STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STEPS-1:0], in_valid};
        end
    end

    // 255 * rem as rem * 256 - rem
    always_ff @(posedge aclk) begin
        if (en) begin
            part_reg[0]   <= (PW'(in_rem) << STEPS) - PW'(in_rem);
            quo_reg[0]    <= '0;
            sector_reg[0] <= in_sector;
            for (int i = 1; i <= STEPS; i++) begin
                part_reg[i]   <= part_next[i];
                quo_reg[i]    <= quo_next[i];
                sector_reg[i] <= sector_reg[i-1];
            end
        end
    end

    assign out_valid   = valid_reg[STEPS];
    assign out_sector  = sector_reg[STEPS];
    assign out_up      = quo_reg[STEPS];
    assign out_inexact = |part_reg[STEPS];

endmodule

@@ sv/ihc_palette.sv @@
// sector to rgb selection, then the palette mode
module ihc_palette (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  ihc_pkg::palette_mode_t        mode,
    input  logic                          in_valid,
    input  ihc_pkg::sector_t              in_sector,
    input  logic [ihc_pkg::CHAN_BITS-1:0] in_up,
    input  logic                          in_inexact,
    output logic                          out_valid,
    output logic [ihc_pkg::CHAN_BITS-1:0] out_red,
    output logic [ihc_pkg::CHAN_BITS-1:0] out_green,
    output logic [ihc_pkg::CHAN_BITS-1:0] out_blue
);

    localparam int CB = ihc_pkg::CHAN_BITS;

    logic [CB-1:0] down;
    logic [CB-1:0] red_next,  green_next,  blue_next;
    logic [CB-1:0] red_reg,   green_reg,   blue_reg;
    logic [CB-1:0] red2_next, green2_next, blue2_next;
    logic [CB-1:0] red2_reg,  green2_reg,  blue2_reg;
    logic [CB:0]   mix_sum;
    logic [CB-1:0] mix_quarter;
    logic [CB-1:0] mix_floored;
    logic [1:0]    valid_reg;

    // falling ramp is 255 minus the rising ramp rounded up
    always_comb begin
        down = ihc_pkg::CHAN_FULL - in_up - CB'(in_inexact);
        unique case (in_sector)
            ihc_pkg::SECTOR_GREEN_UP: begin
                red_next = ihc_pkg::CHAN_FULL; green_next = in_up;
                blue_next = ihc_pkg::CHAN_ZERO;
            end
            ihc_pkg::SECTOR_RED_DOWN: begin
                red_next = down; green_next = ihc_pkg::CHAN_FULL;
                blue_next = ihc_pkg::CHAN_ZERO;
            end
            ihc_pkg::SECTOR_BLUE_UP: begin
                red_next = ihc_pkg::CHAN_ZERO; green_next = ihc_pkg::CHAN_FULL;
                blue_next = in_up;
            end
            ihc_pkg::SECTOR_GREEN_DOWN: begin
                red_next = ihc_pkg::CHAN_ZERO; green_next = down;
                blue_next = ihc_pkg::CHAN_FULL;
            end
            ihc_pkg::SECTOR_RED_UP: begin
                red_next = in_up; green_next = ihc_pkg::CHAN_ZERO;
                blue_next = ihc_pkg::CHAN_FULL;
            end
            ihc_pkg::SECTOR_BLUE_DOWN: begin
                red_next = ihc_pkg::CHAN_FULL; green_next = ihc_pkg::CHAN_ZERO;
                blue_next = down;
            end
            default: begin
                red_next = ihc_pkg::CHAN_FULL; green_next = ihc_pkg::CHAN_ZERO;
                blue_next = ihc_pkg::CHAN_ZERO;
            end
        endcase
    end

    always_comb begin
        red2_next   = red_reg;
        green2_next = green_reg;
        blue2_next  = blue_reg;
        unique case (mode)
            ihc_pkg::MODE_RED:  mix_sum = {1'b0, blue_reg} + {1'b0, green_reg};
            ihc_pkg::MODE_BLUE: mix_sum = {1'b0, green_reg} + {1'b0, red_reg};
            default:            mix_sum = '0;
        endcase
        mix_quarter = {1'b0, mix_sum[CB:2]};
        mix_floored = (mix_quarter < ihc_pkg::CHAN_FLOOR) ? ihc_pkg::CHAN_FLOOR : mix_quarter;
        unique case (mode)
            ihc_pkg::MODE_PLAIN: ;
            ihc_pkg::MODE_RED:   red2_next = mix_floored;
            ihc_pkg::MODE_BLUE:  blue2_next = mix_floored;
            ihc_pkg::MODE_GREY: begin
                red2_next   = blue_reg;
                green2_next = blue_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            red2_reg   <= red2_next;
            green2_reg <= green2_next;
            blue2_reg  <= blue2_next;
        end
    end

    assign out_valid = valid_reg[1];
    assign out_red   = red2_reg;
    assign out_green = green2_reg;
    assign out_blue  = blue2_reg;

endmodule

@@ sv/iteration_hue_colorizer_unit.sv @@
// top level: config registers, hue pipeline and output skid stage
//
//  port group   dir  payload                               accepted when
//  s_           in   tdata: iteration_count                s_tvalid & s_tready
//  m_           out  tdata: red, green, blue               m_tvalid & m_tready
//  cfg_wr_      in   index 0 iteration_limit, 1 mode       cfg_wr_en
//
//  one item a cycle while s_tready is high; 16 register stages
//  (clamp, 3 sector steps, 8+1 ramp steps, 2 colour stages, output register)
//  aresetn is synchronous; it empties the pipeline and loads limit 100, mode 0
//  a held m_ result parks the next item in the skid register; s_tready falls
//  only while that register is full
module iteration_hue_colorizer_unit #(
    parameter int COUNT_BITS = ihc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((COUNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // iteration_count
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [3 * ihc_pkg::CHAN_BITS - 1:0]  m_tdata,      // red, green, blue
    input  logic                                 cfg_wr_en,
    input  logic [ihc_pkg::CFG_INDEX_BITS-1:0]   cfg_wr_index,
    input  logic [COUNT_BITS-1:0]                cfg_wr_data
);

    localparam int OW = 3 * ihc_pkg::CHAN_BITS;

    logic [COUNT_BITS-1:0]          limit_reg;
    ihc_pkg::palette_mode_t         mode_reg;
    logic [COUNT_BITS-1:0]          limit_eff;
    logic                           en;

    logic                           sec_valid;
    ihc_pkg::sector_t               sec_sector;
    logic [COUNT_BITS-1:0]          sec_rem;
    logic                           ramp_valid;
    ihc_pkg::sector_t               ramp_sector;
    logic [ihc_pkg::CHAN_BITS-1:0]  ramp_up;
    logic                           ramp_inexact;
    logic                           pal_valid;
    logic [ihc_pkg::CHAN_BITS-1:0]  pal_red, pal_green, pal_blue;
    logic [OW-1:0]                  pal_data;

    logic                           out_valid_reg, out_valid_next;
    logic [OW-1:0]                  out_data_reg,  out_data_next;
    logic                           skid_valid_reg, skid_valid_next;
    logic [OW-1:0]                  skid_data_reg,  skid_data_next;
    logic                           out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= COUNT_BITS'(ihc_pkg::LIMIT_RESET);
            mode_reg  <= ihc_pkg::MODE_PLAIN;
        end else if (cfg_wr_en) begin
            unique case (ihc_pkg::cfg_reg_t'(cfg_wr_index))
                ihc_pkg::REG_ITERATION_LIMIT: limit_reg <= cfg_wr_data;
                ihc_pkg::REG_PALETTE_MODE:
                    mode_reg <= ihc_pkg::palette_mode_t'(cfg_wr_data[1:0]);
            endcase
        end
    end

    // zero limit acts as one
    assign limit_eff = (limit_reg == '0) ? COUNT_BITS'(1) : limit_reg;
    assign en        = !skid_valid_reg;
    assign s_tready  = en;

    ihc_sector #(.COUNT_BITS(COUNT_BITS)) u_sector (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_count   (s_tdata[COUNT_BITS-1:0]),
        .limit      (limit_eff),
        .out_valid  (sec_valid),
        .out_sector (sec_sector),
        .out_rem    (sec_rem)
    );

    ihc_ramp #(.COUNT_BITS(COUNT_BITS)) u_ramp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (sec_valid),
        .in_sector   (sec_sector),
        .in_rem      (sec_rem),
        .limit       (limit_eff),
        .out_valid   (ramp_valid),
        .out_sector  (ramp_sector),
        .out_up      (ramp_up),
        .out_inexact (ramp_inexact)
    );

    ihc_palette u_palette (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .mode       (mode_reg),
        .in_valid   (ramp_valid),
        .in_sector  (ramp_sector),
        .in_up      (ramp_up),
        .in_inexact (ramp_inexact),
        .out_valid  (pal_valid),
        .out_red    (pal_red),
        .out_green  (pal_green),
        .out_blue   (pal_blue)
    );

    assign pal_data = {pal_blue, pal_green, pal_red};
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (pal_valid) begin
            if (out_free) begin
                out_valid_next = 1'b1;
                out_data_next  = pal_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = pal_data;
            end
        end else if (out_free) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ dv/ihc_colour_checker.sv @@
// checker for the iteration hue colorizer: predicts each colour and compares it on the m_ side
`timescale 1ns / 100ps

module ihc_colour_checker
    import ihc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [15:0]                 s_tdata,      // iteration_count
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [3*CHAN_BITS-1:0]      m_tdata,      // red, green, blue
    input  logic                        cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_wr_index,
    input  logic [15:0]                 cfg_wr_data,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] red;
    } colour_t;

    colour_t       colour_queue[$];
    logic [15:0]   limit_reg;
    palette_mode_t mode_reg;

    function automatic logic [CHAN_BITS-1:0] floor_tint(logic [CHAN_BITS-1:0] a,
                                                         logic [CHAN_BITS-1:0] b);
        logic [CHAN_BITS:0] shade;
        shade = ({1'b0, a} + {1'b0, b}) >> 2;
        return (shade < CHAN_FLOOR) ? CHAN_FLOOR : shade[CHAN_BITS-1:0];
    endfunction

    function automatic colour_t hue_colour(logic [15:0] count, logic [15:0] limit,
                                           palette_mode_t mode);
        longint unsigned lim, c, sec, rem, up, down;
        colour_t px;
        lim  = (limit == 0) ? 1 : limit;
        c    = (count > lim) ? lim : count;
        sec  = (6 * c) / lim;
        rem  = 6 * c - sec * lim;
        up   = (255 * rem) / lim;
        down = (255 * (lim - rem)) / lim;
        case (sector_t'(sec))
            SECTOR_GREEN_UP: begin
                px.red = CHAN_FULL; px.green = up[7:0]; px.blue = CHAN_ZERO;
            end
            SECTOR_RED_DOWN: begin
                px.red = down[7:0]; px.green = CHAN_FULL; px.blue = CHAN_ZERO;
            end
            SECTOR_BLUE_UP: begin
                px.red = CHAN_ZERO; px.green = CHAN_FULL; px.blue = up[7:0];
            end
            SECTOR_GREEN_DOWN: begin
                px.red = CHAN_ZERO; px.green = down[7:0]; px.blue = CHAN_FULL;
            end
            SECTOR_RED_UP: begin
                px.red = up[7:0]; px.green = CHAN_ZERO; px.blue = CHAN_FULL;
            end
            SECTOR_BLUE_DOWN: begin
                px.red = CHAN_FULL; px.green = CHAN_ZERO; px.blue = down[7:0];
            end
            default: begin
                px.red = CHAN_FULL; px.green = CHAN_ZERO; px.blue = CHAN_ZERO;
            end
        endcase
        case (mode)
            MODE_RED:  px.red = floor_tint(px.blue, px.green);
            MODE_BLUE: px.blue = floor_tint(px.green, px.red);
            MODE_GREY: begin
                px.red   = px.blue;
                px.green = px.blue;
            end
            default: ;
        endcase
        return px;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        colour_t want;
        colour_t got;
        if (!aresetn) begin
            colour_queue.delete();
            limit_reg <= 16'(LIMIT_RESET);
            mode_reg  <= MODE_PLAIN;
        end else begin
            if (m_tvalid && m_tready) begin
                got = colour_t'(m_tdata);
                if (colour_queue.size() == 0) begin
                    $display("%0t unexpected colour: expected none, got %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = colour_queue.pop_front();
                    if (got.red !== want.red) begin
                        $display("%0t red mismatch: expected %0d, got %0d",
                                 $time, want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $display("%0t green mismatch: expected %0d, got %0d",
                                 $time, want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $display("%0t blue mismatch: expected %0d, got %0d",
                                 $time, want.blue, got.blue);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                colour_queue.push_back(hue_colour(s_tdata, limit_reg, mode_reg));
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_wr_index))
                    REG_ITERATION_LIMIT: limit_reg <= cfg_wr_data;
                    REG_PALETTE_MODE:    mode_reg  <= palette_mode_t'(cfg_wr_data[1:0]);
                    default: ;
                endcase
            end
        end
        pending <= colour_queue.size();
    end

endmodule

@@ dv/tb.sv @@
// testbench top for the iteration hue colorizer: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb;
    import ihc_pkg::*;

    localparam int LATENCY    = 19;
    localparam int WATCHDOG   = 3000;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 125;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [15:0]                s_tdata;      // iteration_count
    logic                       m_tvalid;
    logic                       m_tready;
    logic [3*CHAN_BITS-1:0]     m_tdata;      // red, green, blue
    logic                       cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0]  cfg_wr_index;
    logic [15:0]                cfg_wr_data;

    int   fail_count;
    int   pending;
    logic s_took;
    int   quiet_cycles;
    int   src_rate;
    int   sink_rate;

    iteration_hue_colorizer_unit #(.COUNT_BITS(16)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    ihc_colour_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        s_took <= s_tvalid && s_tready;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (aresetn && sink_rate != 0 && $urandom_range(1, sink_rate) == 1) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_count(input logic [15:0] count);
        if (src_rate != 0 && $urandom_range(1, src_rate) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= count;
        do @(negedge aclk); while (!s_took);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic load_palette(input logic [15:0] limit, input logic [15:0] mode_word);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_ITERATION_LIMIT;
        cfg_wr_data  <= limit;
        @(negedge aclk);
        cfg_wr_index <= REG_PALETTE_MODE;
        cfg_wr_data  <= mode_word;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 6))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'($urandom_range(2, 12));
            3: return 16'd100;
            4: return 16'hffff;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_count(input logic [15:0] limit);
        int lim;
        lim = (limit == 0) ? 1 : limit;
        case ($urandom_range(0, 6))
            4: return 16'($urandom_range(0, 65535));
            5: return 16'(($urandom_range(0, 6) * lim) / 6 + $urandom_range(0, 1));
            6: return 16'(lim + $urandom_range(0, 3));
            default: return 16'($urandom_range(0, lim));
        endcase
    endfunction

    initial begin
        logic [15:0] limit;
        logic [15:0] mode_word;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_ITERATION_LIMIT;
        cfg_wr_data  = '0;
        quiet_cycles = 0;
        src_rate     = 4;
        sink_rate    = 4;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values: limit 100, plain hue, every sector edge and saturation
        send_count(16'd0);   send_count(16'd1);   send_count(16'd16);
        send_count(16'd17);  send_count(16'd33);  send_count(16'd34);
        send_count(16'd50);  send_count(16'd51);  send_count(16'd66);
        send_count(16'd67);  send_count(16'd83);  send_count(16'd84);
        send_count(16'd99);  send_count(16'd100); send_count(16'd101);
        send_count(16'hffff);

        // zero limit acts as one; mode word with high bits set
        wait_drained();
        load_palette(16'd0, 16'hfffc | MODE_RED);
        send_count(16'd0);   send_count(16'd1);   send_count(16'hffff);

        wait_drained();
        load_palette(16'hffff, {14'h2aaa, MODE_BLUE});
        send_count(16'd0);     send_count(16'd10922); send_count(16'd10923);
        send_count(16'd32768); send_count(16'd43690); send_count(16'hffff);

        wait_drained();
        load_palette(16'd1, {14'd0, MODE_GREY});
        send_count(16'd0);   send_count(16'd1);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            limit = pick_limit();
            mode_word = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 3));
            load_palette(limit, mode_word);
            if (phase == PHASES - 1) begin
                src_rate  = 0;
                sink_rate = 0;
            end else begin
                src_rate  = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 10);
                sink_rate = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 10);
            end
            for (int n = 0; n < PHASE_LEN; n++)
                send_count(pick_count(limit));
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (LATENCY * 2) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ihc_pkg.sv
sv/ihc_sector.sv
sv/ihc_ramp.sv
sv/ihc_palette.sv
sv/iteration_hue_colorizer_unit.sv
dv/ihc_colour_checker.sv
dv/tb.sv
